[src/bsld_pkg.sv]
package bsld_pkg;

  // Result status codes, carried on m_axis_tuser
  typedef enum logic [2:0] {
    STATUS_MORE     = 3'd0,
    STATUS_DONE     = 3'd1,
    STATUS_BAD_TAG  = 3'd2,
    STATUS_TOO_LONG = 3'd3,
    STATUS_TOO_WIDE = 3'd4
  } status_t;

  localparam logic [7:0]  TAG_SEQUENCE    = 8'h30;
  localparam logic [6:0]  MAX_LEN_BYTES   = 7'd4;
  localparam logic [31:0] DEFAULT_MAX_LEN = 32'd134217728;
  // Smallest packet: tag byte plus a length byte
  localparam logic [31:0] MIN_PACKET_LEN  = 32'd2;

endpackage

[src/ber_sequence_length_deframer_unit.sv]
// BER sequence length deframer. Bytes enter on s_axis one per beat and are cut
// into tag-length-value packets: tag 0x30, then a short-form length byte
// (below 0x80) or a long-form byte whose low 7 bits count up to four
// big-endian length bytes, then the content. Every input byte gives exactly
// one result beat on m_axis: tuser carries the status (more needed, complete,
// bad tag, too long, length field too wide) and tdata the total packet length,
// header included, on a complete beat and zero otherwise. A packet whose total
// exceeds max_packet_len is flagged at its last header byte. Errors are sticky
// until rst. The block takes one byte per clock cycle unless the output buffer
// is full; the packet state is updated by combinational logic (one 33-bit add
// and compare for the length check) and the result is registered into the
// output buffer. This two-entry buffer lets a byte be taken while a result
// waits, so s_axis_tready only drops once a byte is taken during a stall.
// cfg_wr_en writes max_packet_len (reset value 128 MiB); write only when idle.
module ber_sequence_length_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] packet_length
  output logic [2:0]  m_axis_tuser   // [2:0] status
);

  // Packet phase; the last three are sticky error states
  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN,
    PH_LENBYTES,
    PH_CONTENT,
    PH_ERR_TAG,
    PH_ERR_LONG,
    PH_ERR_WIDE
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] content_length, content_length_next;
  logic [31:0] bytes_seen, bytes_seen_next;
  logic [31:0] total_length, total_length_next;
  logic [31:0] max_packet_len;

  // Output buffer: main register plus skid entry
  logic                  skid_valid;
  bsld_pkg::status_t     skid_status;
  logic [31:0]           skid_len;
  bsld_pkg::status_t     out_status;
  logic [31:0]           out_len;

  logic                  accept;
  bsld_pkg::status_t     res_status;
  logic [31:0]           res_len;

  // Header completion path
  logic        do_hdr;
  logic [31:0] seen_inc;
  logic [31:0] lb_content;
  logic [31:0] hdr_content;
  logic [31:0] hdr_seen;
  logic [32:0] hdr_total;
  logic        too_long;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = out_len;
  assign m_axis_tuser  = out_status;

  assign seen_inc    = bytes_seen + 32'd1;
  assign lb_content  = {content_length[23:0], s_axis_tdata};
  // Long-form length byte with no length bytes means empty content
  assign hdr_content = (phase == PH_LENBYTES) ? lb_content :
                       (s_axis_tdata[7] ? 32'd0 : {25'd0, s_axis_tdata[6:0]});
  assign hdr_seen    = (phase == PH_LENBYTES) ? seen_inc : bsld_pkg::MIN_PACKET_LEN;
  // Compared at 33 bits so totals past 32 bits count as too long
  assign hdr_total   = {1'b0, hdr_seen} + {1'b0, hdr_content};
  assign too_long    = hdr_total > {1'b0, max_packet_len};

  always_comb begin
    phase_next             = phase;
    length_bytes_left_next = length_bytes_left;
    content_length_next    = content_length;
    bytes_seen_next        = bytes_seen;
    total_length_next      = total_length;
    res_status             = bsld_pkg::STATUS_MORE;
    res_len                = 32'd0;
    do_hdr                 = 1'b0;

    case (phase)
      PH_TAG: begin
        if (s_axis_tdata != bsld_pkg::TAG_SEQUENCE) begin
          phase_next = PH_ERR_TAG;
          res_status = bsld_pkg::STATUS_BAD_TAG;
        end else begin
          bytes_seen_next        = 32'd1;
          content_length_next    = 32'd0;
          total_length_next      = 32'd0;
          length_bytes_left_next = 3'd0;
          phase_next             = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_seen_next = bsld_pkg::MIN_PACKET_LEN;
        if (!s_axis_tdata[7]) begin
          content_length_next = {24'd0, s_axis_tdata};
          do_hdr              = 1'b1;
        end else if (s_axis_tdata[6:0] > bsld_pkg::MAX_LEN_BYTES) begin
          phase_next = PH_ERR_WIDE;
          res_status = bsld_pkg::STATUS_TOO_WIDE;
        end else if (s_axis_tdata[6:0] == 7'd0) begin
          content_length_next = 32'd0;
          do_hdr              = 1'b1;
        end else begin
          length_bytes_left_next = s_axis_tdata[2:0];
          content_length_next    = 32'd0;
          phase_next             = PH_LENBYTES;
        end
      end
      PH_LENBYTES: begin
        bytes_seen_next        = seen_inc;
        content_length_next    = lb_content;
        length_bytes_left_next = length_bytes_left - 3'd1;
        if (length_bytes_left == 3'd1) begin
          do_hdr = 1'b1;
        end
      end
      PH_CONTENT: begin
        bytes_seen_next = seen_inc;
        if (seen_inc >= total_length) begin
          res_status      = bsld_pkg::STATUS_DONE;
          res_len         = total_length;
          phase_next      = PH_TAG;
          bytes_seen_next = 32'd0;
        end
      end
      PH_ERR_TAG: begin
        res_status = bsld_pkg::STATUS_BAD_TAG;
      end
      PH_ERR_LONG: begin
        res_status = bsld_pkg::STATUS_TOO_LONG;
      end
      default: begin
        phase_next = PH_ERR_WIDE;
        res_status = bsld_pkg::STATUS_TOO_WIDE;
      end
    endcase

    // Header finished: limit check, then complete now or wait for content
    if (do_hdr) begin
      if (too_long) begin
        phase_next = PH_ERR_LONG;
        res_status = bsld_pkg::STATUS_TOO_LONG;
      end else begin
        total_length_next = hdr_total[31:0];
        if (hdr_content == 32'd0) begin
          res_status      = bsld_pkg::STATUS_DONE;
          res_len         = hdr_total[31:0];
          phase_next      = PH_TAG;
          bytes_seen_next = 32'd0;
        end else begin
          phase_next = PH_CONTENT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG;
      length_bytes_left <= 3'd0;
      content_length    <= 32'd0;
      bytes_seen        <= 32'd0;
      total_length      <= 32'd0;
      max_packet_len    <= bsld_pkg::DEFAULT_MAX_LEN;
    end else begin
      if (cfg_wr_en) begin
        max_packet_len <= cfg_wr_data;
      end
      if (accept) begin
        phase             <= phase_next;
        length_bytes_left <= length_bytes_left_next;
        content_length    <= content_length_next;
        bytes_seen        <= bytes_seen_next;
        total_length      <= total_length_next;
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        out_status <= skid_status;
        out_len    <= skid_len;
      end else begin
        out_status <= res_status;
        out_len    <= res_len;
      end
    end else if (accept) begin
      skid_status <= res_status;
      skid_len    <= res_len;
    end
  end

endmodule

[src/bsld_checker.sv]
module bsld_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [31:0] cfg_wr_data,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // Buffer empty after reset: no beat out, byte input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output buffer not empty after reset");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // Length only on a complete beat
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != bsld_pkg::STATUS_DONE) |-> m_axis_tdata == 32'd0)
    else $error("packet length on a non-complete beat");

  // A complete packet holds at least tag and length byte
  a_len_min: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == bsld_pkg::STATUS_DONE) |->
      m_axis_tdata >= bsld_pkg::MIN_PACKET_LEN)
    else $error("complete packet shorter than its header");

  // Input stalls only while a result beat is stuck downstream
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

endmodule

bind ber_sequence_length_deframer_unit bsld_checker u_bsld_checker (.*);
